>>> hdl/bcip_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bcip_pkg;

    // Field widths of the item and the register
    localparam int COORD_W = 24;   // signed Q15.8 coordinates
    localparam int HALF_W  = 23;   // unsigned Q15.8 half sizes
    localparam int IDX_W   = 6;    // vertex slot field
    localparam int CNT_W   = 7;    // vertex_count register
    localparam int CORN_W  = 3;    // hit_corner field

    // One stored vertex: {x, y}
    localparam int VERT_W  = 2 * COORD_W;

    // Corner and edge terms relative to the polygon origin are exact in 26 bits,
    // so are their products in 52 bits.
    localparam int REL_W   = 26;
    localparam int PROD_W  = 2 * REL_W;

    localparam int MAX_VERTICES_DEF = 64;

    // Item opcodes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Corner codes, in test order
    localparam logic [CORN_W-1:0] CORNER_UL   = 3'd0;
    localparam logic [CORN_W-1:0] CORNER_LL   = 3'd1;
    localparam logic [CORN_W-1:0] CORNER_LR   = 3'd2;
    localparam logic [CORN_W-1:0] CORNER_UR   = 3'd3;
    localparam logic [CORN_W-1:0] CORNER_NONE = 3'd4;

    // Controller to datapath
    typedef struct packed {
        logic load_query;  // capture the query and clear the crossing parity
        logic wr_en;       // write the incoming vertex
        logic rd_en;       // read one vertex of the walk
        logic rd_first;    // that read is vertex 0 (no edge closes on it)
        logic out_load;    // move the verdict into the output register
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic pipe_busy;   // an edge is still in flight
    } t_dp_status;

endpackage

`default_nettype wire

>>> hdl/bcip_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module bcip_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> hdl/bcip_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module bcip_dp #(
    parameter int MAX_VERTICES = bcip_pkg::MAX_VERTICES_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire bcip_pkg::t_dp_cmd                   i_cmd,
    input  wire logic [$clog2(MAX_VERTICES)-1:0]     i_rd_addr,
    output bcip_pkg::t_dp_status                     o_status,
    input  wire logic [bcip_pkg::IDX_W-1:0]          i_vertex_index,
    input  wire logic signed [bcip_pkg::COORD_W-1:0] i_vertex_x,
    input  wire logic signed [bcip_pkg::COORD_W-1:0] i_vertex_y,
    input  wire logic signed [bcip_pkg::COORD_W-1:0] i_hull_x,
    input  wire logic signed [bcip_pkg::COORD_W-1:0] i_hull_y,
    input  wire logic signed [bcip_pkg::COORD_W-1:0] i_box_x,
    input  wire logic signed [bcip_pkg::COORD_W-1:0] i_box_y,
    input  wire logic [bcip_pkg::HALF_W-1:0]         i_half_width,
    input  wire logic [bcip_pkg::HALF_W-1:0]         i_half_height,
    output logic                                     o_inside_res,
    output logic [bcip_pkg::CORN_W-1:0]              o_hit_corner
);

    localparam int AW     = $clog2(MAX_VERTICES);
    localparam int REL_W  = bcip_pkg::REL_W;
    localparam int PROD_W = bcip_pkg::PROD_W;
    localparam int CW     = bcip_pkg::COORD_W;

    // Query terms, relative to the polygon origin
    logic signed [REL_W-1:0] w_box_x, w_box_y, w_hull_x, w_hull_y, w_hw, w_hh;
    logic signed [REL_W-1:0] r_rcx_l, r_rcx_r, r_rcy_u, r_rcy_d;

    // Vertex walk
    logic [bcip_pkg::VERT_W-1:0] w_rd_data;
    logic                        r_rd_vld, r_rd_first;
    logic signed [REL_W-1:0]     w_cur_x, w_cur_y;
    logic signed [REL_W-1:0]     r_prev_x, r_prev_y;

    // Edge stage
    logic                    r_s2_vld;
    logic signed [REL_W-1:0] r_dx, r_dy, r_ex_l, r_ex_r, r_ey_u, r_ey_d;
    logic                    r_s2_str_u, r_s2_str_d;

    // Product stage
    logic                     r_s3_vld;
    logic signed [PROD_W-1:0] w_lhs_l, w_lhs_r, w_rhs_u, w_rhs_d;
    logic signed [PROD_W-1:0] r_lhs_l, r_lhs_r, r_rhs_u, r_rhs_d;
    logic                     r_s3_str_u, r_s3_str_d, r_s3_dy_neg;

    // Crossing parity per corner: UL, LL, LR, UR
    logic [3:0] w_cross;
    logic [3:0] r_par;

    logic                          w_hit;
    logic [bcip_pkg::CORN_W-1:0]   w_corner;

    assign w_box_x  = REL_W'(i_box_x);
    assign w_box_y  = REL_W'(i_box_y);
    assign w_hull_x = REL_W'(i_hull_x);
    assign w_hull_y = REL_W'(i_hull_y);
    assign w_hw     = REL_W'({1'b0, i_half_width});
    assign w_hh     = REL_W'({1'b0, i_half_height});

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_query) begin
            r_rcx_l <= w_box_x - w_hw - w_hull_x;
            r_rcx_r <= w_box_x + w_hw - w_hull_x;
            r_rcy_u <= w_box_y + w_hh - w_hull_y;
            r_rcy_d <= w_box_y - w_hh - w_hull_y;
        end
    end

    bcip_ram #(
        .WIDTH (bcip_pkg::VERT_W),
        .DEPTH (MAX_VERTICES)
    ) u_vert_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_en),
        .i_wr_addr (AW'(i_vertex_index)),
        .i_wr_data ({i_vertex_x, i_vertex_y}),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (i_rd_addr),
        .o_rd_data (w_rd_data)
    );

    assign w_cur_x = REL_W'($signed(w_rd_data[2*CW-1:CW]));
    assign w_cur_y = REL_W'($signed(w_rd_data[CW-1:0]));

    // Edge from the previous vertex to the current one
    always_ff @(posedge i_clk) begin
        if (r_rd_vld) begin
            r_prev_x <= w_cur_x;
            r_prev_y <= w_cur_y;
        end
        r_dx       <= w_cur_x - r_prev_x;
        r_dy       <= w_cur_y - r_prev_y;
        r_ex_l     <= r_rcx_l - r_prev_x;
        r_ex_r     <= r_rcx_r - r_prev_x;
        r_ey_u     <= r_rcy_u - r_prev_y;
        r_ey_d     <= r_rcy_d - r_prev_y;
        r_s2_str_u <= (r_prev_y > r_rcy_u) != (w_cur_y > r_rcy_u);
        r_s2_str_d <= (r_prev_y > r_rcy_d) != (w_cur_y > r_rcy_d);
    end

    assign w_lhs_l = PROD_W'(r_ex_l) * PROD_W'(r_dy);
    assign w_lhs_r = PROD_W'(r_ex_r) * PROD_W'(r_dy);
    assign w_rhs_u = PROD_W'(r_dx) * PROD_W'(r_ey_u);
    assign w_rhs_d = PROD_W'(r_dx) * PROD_W'(r_ey_d);

    always_ff @(posedge i_clk) begin
        r_lhs_l     <= w_lhs_l;
        r_lhs_r     <= w_lhs_r;
        r_rhs_u     <= w_rhs_u;
        r_rhs_d     <= w_rhs_d;
        r_s3_str_u  <= r_s2_str_u;
        r_s3_str_d  <= r_s2_str_d;
        r_s3_dy_neg <= r_dy[REL_W-1];
    end

    // Crossing when the corner lies strictly left of the edge at its y
    assign w_cross[0] = r_s3_str_u &&
                        (r_s3_dy_neg ? (r_lhs_l > r_rhs_u) : (r_lhs_l < r_rhs_u));
    assign w_cross[1] = r_s3_str_d &&
                        (r_s3_dy_neg ? (r_lhs_l > r_rhs_d) : (r_lhs_l < r_rhs_d));
    assign w_cross[2] = r_s3_str_d &&
                        (r_s3_dy_neg ? (r_lhs_r > r_rhs_d) : (r_lhs_r < r_rhs_d));
    assign w_cross[3] = r_s3_str_u &&
                        (r_s3_dy_neg ? (r_lhs_r > r_rhs_u) : (r_lhs_r < r_rhs_u));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld   <= 1'b0;
            r_rd_first <= 1'b0;
            r_s2_vld   <= 1'b0;
            r_s3_vld   <= 1'b0;
            r_par      <= '0;
        end else begin
            r_rd_vld   <= i_cmd.rd_en;
            r_rd_first <= i_cmd.rd_first;
            r_s2_vld   <= r_rd_vld && !r_rd_first;
            r_s3_vld   <= r_s2_vld;
            if (i_cmd.load_query) begin
                r_par <= '0;
            end else if (r_s3_vld) begin
                r_par <= r_par ^ w_cross;
            end
        end
    end

    assign o_status.pipe_busy = r_rd_vld || r_s2_vld || r_s3_vld;

    // First odd corner wins
    always_comb begin
        w_hit    = |r_par;
        w_corner = bcip_pkg::CORNER_NONE;
        if (r_par[0]) begin
            w_corner = bcip_pkg::CORNER_UL;
        end else if (r_par[1]) begin
            w_corner = bcip_pkg::CORNER_LL;
        end else if (r_par[2]) begin
            w_corner = bcip_pkg::CORNER_LR;
        end else if (r_par[3]) begin
            w_corner = bcip_pkg::CORNER_UR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_inside_res <= w_hit;
            o_hit_corner <= w_corner;
        end
    end

endmodule

`default_nettype wire

>>> hdl/bcip_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module bcip_ctrl #(
    parameter int MAX_VERTICES = bcip_pkg::MAX_VERTICES_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic                            i_op,
    input  wire logic [bcip_pkg::IDX_W-1:0]      i_vertex_index,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [bcip_pkg::CNT_W-1:0]      i_vertex_count,
    output bcip_pkg::t_dp_cmd                    o_cmd,
    output logic [$clog2(MAX_VERTICES)-1:0]      o_rd_addr,
    input  wire bcip_pkg::t_dp_status            i_status
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_RUN    = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } t_state;

    t_state                     r_state, n_state;
    logic [bcip_pkg::CNT_W-1:0] r_vcount;
    logic [CW-1:0]              r_issue, n_issue;
    logic                       r_out_valid, n_out_valid;
    logic [CW-1:0]              w_n;
    logic                       w_accept;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_state == ST_IDLE);
    assign o_valid     = r_out_valid;
    assign w_accept    = i_valid && o_ready;

    assign w_n = (32'(r_vcount) > MAX_VERTICES) ? CW'(MAX_VERTICES) : CW'(r_vcount);
    assign o_rd_addr = r_issue[AW-1:0];

    always_comb begin
        n_state     = r_state;
        n_issue     = r_issue;
        n_out_valid = r_out_valid && !i_ready;
        o_cmd       = '0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_op == bcip_pkg::OP_QUERY) begin
                        o_cmd.load_query = 1'b1;
                        n_issue          = '0;
                        n_state          = ST_RUN;
                    end else begin
                        o_cmd.wr_en = (32'(i_vertex_index) < MAX_VERTICES);
                    end
                end
            end
            ST_RUN: begin
                if (r_issue == w_n) begin
                    n_state = ST_DRAIN;
                end else begin
                    o_cmd.rd_en    = 1'b1;
                    o_cmd.rd_first = (r_issue == '0);
                    n_issue        = r_issue + CW'(1);
                end
            end
            ST_DRAIN: begin
                if (!i_status.pipe_busy) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || i_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_issue     <= '0;
            r_out_valid <= 1'b0;
            r_vcount    <= '0;
        end else begin
            r_state     <= n_state;
            r_issue     <= n_issue;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_vcount <= i_vertex_count;
            end
        end
    end

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_ready))
        else $error("verdict loaded over an untaken word");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_issue <= w_n))
        else $error("vertex walk ran past the vertex count");

    a_port_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.wr_en && o_cmd.rd_en))
        else $error("vertex load during a walk");

    a_finish_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINISH) |-> !i_status.pipe_busy)
        else $error("verdict taken with edges still in flight");

    a_query_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_query |=> (r_state == ST_RUN) && (r_issue == '0))
        else $error("query did not start its walk");

endmodule

`default_nettype wire

>>> hdl/box_corner_in_polygon_test.sv
// Result: a query walks n vertices (vertex_count clamped to MAX_VERTICES), closing one
//   edge per cycle for all four corners at once, and returns one word; loads give none.
// Throughput: loads are taken one per cycle while idle; a query blocks new items until
//   its verdict is loaded, which waits while an earlier word is still untaken.
// Reset (synchronous, active low) idles the controller, drops any pending word,
//   and clears vertex_count; vertex RAM contents are kept and undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none

// Box corner in polygon test.
//
// A polygon is held as a vertex list in a single RAM, loaded one vertex per
// load word. A query word gives the polygon origin and a box; each of the
// four box corners is tested by the even-odd ray rule against the polygon
// shifted by the origin.
//
// Structure:
//   bcip_ctrl - handshakes, the vertex_count register and the query
//               sequencer (idle, walk, drain, finish).
//   bcip_dp   - vertex RAM, corner terms, a three-stage edge pipe
//               (read, differences, cross products) and the parity bits.
//
// The crossing test avoids division: for an edge A->B straddling the
// corner's y, the corner lies left of the crossing point when
// (cx-ax)*dy < (bx-ax)*(cy-ay) for dy > 0, and with the compare flipped
// for dy < 0. Only four products are needed per edge since the corners
// share two x and two y values.
//
// The output register parts the result side from the input side: loads
// and new queries are taken while a verdict still waits; a finished query
// holds in its last state until the waiting word is taken.
module box_corner_in_polygon_test #(
    parameter int MAX_VERTICES = bcip_pkg::MAX_VERTICES_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Item channel
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic                                i_op,
    input  wire logic [bcip_pkg::IDX_W-1:0]          i_vertex_index,
    input  wire logic signed [bcip_pkg::COORD_W-1:0] i_vertex_x,
    input  wire logic signed [bcip_pkg::COORD_W-1:0] i_vertex_y,
    input  wire logic signed [bcip_pkg::COORD_W-1:0] i_hull_x,
    input  wire logic signed [bcip_pkg::COORD_W-1:0] i_hull_y,
    input  wire logic signed [bcip_pkg::COORD_W-1:0] i_box_x,
    input  wire logic signed [bcip_pkg::COORD_W-1:0] i_box_y,
    input  wire logic [bcip_pkg::HALF_W-1:0]         i_half_width,
    input  wire logic [bcip_pkg::HALF_W-1:0]         i_half_height,
    // Result channel
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic                                     o_inside_res,
    output logic [bcip_pkg::CORN_W-1:0]              o_hit_corner,
    // Configuration channel: vertex_count
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [bcip_pkg::CNT_W-1:0]          i_vertex_count
);

    bcip_pkg::t_dp_cmd              w_cmd;
    bcip_pkg::t_dp_status           w_status;
    logic [$clog2(MAX_VERTICES)-1:0] w_rd_addr;

    bcip_ctrl #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_op           (i_op),
        .i_vertex_index (i_vertex_index),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_vertex_count (i_vertex_count),
        .o_cmd          (w_cmd),
        .o_rd_addr      (w_rd_addr),
        .i_status       (w_status)
    );

    bcip_dp #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_rd_addr      (w_rd_addr),
        .o_status       (w_status),
        .i_vertex_index (i_vertex_index),
        .i_vertex_x     (i_vertex_x),
        .i_vertex_y     (i_vertex_y),
        .i_hull_x       (i_hull_x),
        .i_hull_y       (i_hull_y),
        .i_box_x        (i_box_x),
        .i_box_y        (i_box_y),
        .i_half_width   (i_half_width),
        .i_half_height  (i_half_height),
        .o_inside_res   (o_inside_res),
        .o_hit_corner   (o_hit_corner)
    );

endmodule

`default_nettype wire

>>> dv/testbench.sv
`timescale 1ns / 1ps

// Point-in-polygon box test bench: a queue of item words feeds a driver,
// a monitor predicts each query's verdict at acceptance and checks the
// verdict words in order.
module testbench;

    localparam int     IDX_W         = bcip_pkg::IDX_W;
    localparam int     COORD_W       = bcip_pkg::COORD_W;
    localparam int     HALF_W        = bcip_pkg::HALF_W;
    localparam int     CORN_W        = bcip_pkg::CORN_W;
    localparam int     CNT_W         = bcip_pkg::CNT_W;
    localparam int     MAX_VERTS     = bcip_pkg::MAX_VERTICES_DEF;
    // Settling margin for a query that reads up to MAX_VERTS vertices and drains its pipeline.
    localparam int     SETTLE_CYCLES = MAX_VERTS + 16;
    localparam longint UNIT          = 256;           // 1.0 in Q15.8
    localparam longint C_MAX         = 8388607;
    localparam longint C_MIN         = -8388608;
    localparam longint H_MAX         = 8388607;

    // One item word as the sender presents it.
    typedef struct packed {
        logic                      op;
        logic [IDX_W-1:0]          slot;
        logic signed [COORD_W-1:0] vx;
        logic signed [COORD_W-1:0] vy;
        logic signed [COORD_W-1:0] hx;
        logic signed [COORD_W-1:0] hy;
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] by;
        logic [HALF_W-1:0]         hw;
        logic [HALF_W-1:0]         hh;
    } t_poly_word;

    // One verdict word as the block returns it.
    typedef struct packed {
        logic              in_shape;
        logic [CORN_W-1:0] corner;
    } t_hit_word;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_ready;
    logic                      i_op;
    logic [IDX_W-1:0]          i_vertex_index;
    logic signed [COORD_W-1:0] i_vertex_x;
    logic signed [COORD_W-1:0] i_vertex_y;
    logic signed [COORD_W-1:0] i_hull_x;
    logic signed [COORD_W-1:0] i_hull_y;
    logic signed [COORD_W-1:0] i_box_x;
    logic signed [COORD_W-1:0] i_box_y;
    logic [HALF_W-1:0]         i_half_width;
    logic [HALF_W-1:0]         i_half_height;
    logic                      o_valid;
    logic                      i_ready;
    logic                      o_inside_res;
    logic [CORN_W-1:0]         o_hit_corner;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [CNT_W-1:0]          i_vertex_count;

    // Words waiting to be driven, and verdicts waiting to come back.
    t_poly_word  words_to_send[$];
    t_hit_word   hits_due[$];
    t_poly_word  next_word;
    t_hit_word   want;

    // Shadow of the polygon store and the vertex_count register.
    logic signed [COORD_W-1:0] shape_x[MAX_VERTS];
    logic signed [COORD_W-1:0] shape_y[MAX_VERTS];
    logic [CNT_W-1:0]          shape_count = '0;

    logic        item_took = 1'b0;
    bit          bursty = 1'b0;
    int unsigned send_gap = 0;
    int unsigned stall_left = 0;
    int unsigned ready_hold = 0;
    int unsigned shape_radius = 256;
    int unsigned words_made = 0;
    int unsigned mismatches = 0;

    box_corner_in_polygon_test #(
        .MAX_VERTICES(MAX_VERTS)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_op           (i_op),
        .i_vertex_index (i_vertex_index),
        .i_vertex_x     (i_vertex_x),
        .i_vertex_y     (i_vertex_y),
        .i_hull_x       (i_hull_x),
        .i_hull_y       (i_hull_y),
        .i_box_x        (i_box_x),
        .i_box_y        (i_box_y),
        .i_half_width   (i_half_width),
        .i_half_height  (i_half_height),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_inside_res   (o_inside_res),
        .o_hit_corner   (o_hit_corner),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_vertex_count (i_vertex_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Even-odd rule: count the edges that straddle the corner's y and
    // cross the ray to +x strictly right of the corner. The compare is
    // cross-multiplied, so flip it for downward edges.
    function automatic bit corner_in_shape(input longint cx, input longint cy,
                                           input longint ox, input longint oy,
                                           input int unsigned verts);
        int unsigned j;
        int unsigned crossings;
        longint      ax, ay, ex, ey, dy, lhs, rhs;
        crossings = 0;
        for (j = 0; j + 1 < verts; j++) begin
            ax = ox + shape_x[j];
            ay = oy + shape_y[j];
            ex = ox + shape_x[j + 1];
            ey = oy + shape_y[j + 1];
            if ((ay > cy) != (ey > cy)) begin
                dy  = ey - ay;
                lhs = (cx - ax) * dy;
                rhs = (ex - ax) * (cy - ay);
                if (dy > 0 ? (lhs < rhs) : (lhs > rhs))
                    crossings++;
            end
        end
        return crossings[0];
    endfunction

    // Test the corners in the block's order and report the first one inside.
    function automatic t_hit_word predict_box_hit(input longint ox, input longint oy,
                                                  input longint bx, input longint by,
                                                  input longint hw, input longint hh);
        t_hit_word   verdict;
        int unsigned verts;
        verts = (shape_count > MAX_VERTS) ? MAX_VERTS : shape_count;
        verdict.in_shape = 1'b1;
        if (corner_in_shape(bx - hw, by + hh, ox, oy, verts))
            verdict.corner = bcip_pkg::CORNER_UL;
        else if (corner_in_shape(bx - hw, by - hh, ox, oy, verts))
            verdict.corner = bcip_pkg::CORNER_LL;
        else if (corner_in_shape(bx + hw, by - hh, ox, oy, verts))
            verdict.corner = bcip_pkg::CORNER_LR;
        else if (corner_in_shape(bx + hw, by + hh, ox, oy, verts))
            verdict.corner = bcip_pkg::CORNER_UR;
        else begin
            verdict.in_shape = 1'b0;
            verdict.corner   = bcip_pkg::CORNER_NONE;
        end
        return verdict;
    endfunction

    // ------------------------------------------------------------------
    // Monitor: track accepted config and item words, check verdict words
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            item_took   <= 1'b0;
            shape_count = '0;
        end else begin
            item_took <= i_valid && o_ready;
            if (i_cfg_valid && o_cfg_ready)
                shape_count = i_vertex_count;
            if (i_valid && o_ready) begin
                if (i_op == bcip_pkg::OP_LOAD) begin
                    // store the vertex; a slot past the store is dropped
                    if (i_vertex_index < MAX_VERTS) begin
                        shape_x[i_vertex_index] = i_vertex_x;
                        shape_y[i_vertex_index] = i_vertex_y;
                    end
                end else begin
                    hits_due.insert(hits_due.size(),
                                    predict_box_hit(i_hull_x, i_hull_y, i_box_x,
                                                    i_box_y, i_half_width,
                                                    i_half_height));
                end
            end
            if (o_valid && i_ready) begin
                if (hits_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: verdict word, expected none, actual %0d/%0d",
                             $time, o_inside_res, o_hit_corner);
                end else begin
                    want = hits_due.pop_front();
                    if (o_inside_res !== want.in_shape) begin
                        mismatches++;
                        $display("%0t: inside_res mismatch, expected %0d, actual %0d",
                                 $time, want.in_shape, o_inside_res);
                    end
                    if (o_hit_corner !== want.corner) begin
                        mismatches++;
                        $display("%0t: hit_corner mismatch, expected %0d, actual %0d",
                                 $time, want.corner, o_hit_corner);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: hold the current word until taken, then advance, with
    // random gaps while bursty idling is on
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_valid || item_took) begin
            if (send_gap != 0) begin
                send_gap--;
                i_valid <= 1'b0;
            end else if (words_to_send.size() != 0) begin
                next_word = words_to_send.pop_front();
                i_valid        <= 1'b1;
                i_op           <= next_word.op;
                i_vertex_index <= next_word.slot;
                i_vertex_x     <= next_word.vx;
                i_vertex_y     <= next_word.vy;
                i_hull_x       <= next_word.hx;
                i_hull_y       <= next_word.hy;
                i_box_x        <= next_word.bx;
                i_box_y        <= next_word.by;
                i_half_width   <= next_word.hw;
                i_half_height  <= next_word.hh;
                if (bursty && $urandom_range(0, 5) == 0)
                    send_gap = $urandom_range(1, 5);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver: a long hold-off counts down first, then short random stalls.
    always @(negedge i_clk) begin
        if (ready_hold != 0) begin
            ready_hold--;
            i_ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else if (bursty && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 4);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic longint rand_coord();
        return longint'($urandom_range(0, 24'hFFFFFF)) + C_MIN;
    endfunction

    function automatic longint rand_span(input int unsigned r);
        return longint'($urandom_range(0, 2 * r)) - longint'(r);
    endfunction

    task automatic push_load(input int unsigned slot, input longint x, input longint y);
        t_poly_word w;
        w      = '0;
        w.op   = bcip_pkg::OP_LOAD;
        w.slot = slot[IDX_W-1:0];
        w.vx   = x[COORD_W-1:0];
        w.vy   = y[COORD_W-1:0];
        words_to_send.insert(words_to_send.size(), w);
        words_made++;
    endtask

    task automatic push_query(input longint hx, input longint hy, input longint bx,
                              input longint by, input longint hw, input longint hh);
        t_poly_word w;
        w    = '0;
        w.op = bcip_pkg::OP_QUERY;
        w.hx = hx[COORD_W-1:0];
        w.hy = hy[COORD_W-1:0];
        w.bx = bx[COORD_W-1:0];
        w.by = by[COORD_W-1:0];
        w.hw = hw[HALF_W-1:0];
        w.hh = hh[HALF_W-1:0];
        words_to_send.insert(words_to_send.size(), w);
        words_made++;
    endtask

    // Wait until every word is taken and every verdict is back, then let
    // the block finish any trailing load or walk.
    task automatic settle(input int unsigned extra);
        while (words_to_send.size() != 0 || i_valid || hits_due.size() != 0)
            @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic set_vertex_count(input int unsigned value);
        @(negedge i_clk);
        i_cfg_valid    <= 1'b1;
        i_vertex_count <= value[CNT_W-1:0];
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Load a random polygon into slots 0..verts-1; mostly closed on its
    // first vertex, now and then left open.
    task automatic load_shape(input int unsigned verts);
        int unsigned j;
        longint      x0, y0;
        x0 = rand_span(shape_radius);
        y0 = rand_span(shape_radius);
        push_load(0, x0, y0);
        for (j = 1; j + 1 < verts; j++)
            push_load(j, rand_span(shape_radius), rand_span(shape_radius));
        if ($urandom_range(0, 3) == 0)
            push_load(verts - 1, rand_span(shape_radius), rand_span(shape_radius));
        else
            push_load(verts - 1, x0, y0);
    endtask

    // Mostly boxes placed over the shape at a random origin, with some
    // noise words and the odd reload of the shape.
    task automatic feed_queries(input int unsigned verts, input int unsigned k);
        int unsigned pick;
        longint      hx, hy;
        repeat (k) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                push_load($urandom_range(0, MAX_VERTS - 1), rand_coord(), rand_coord());
            end else if (pick < 16) begin
                push_query(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                           $urandom_range(0, H_MAX), $urandom_range(0, H_MAX));
            end else if (pick < 20 && verts >= 2) begin
                load_shape(verts);
            end else begin
                hx = rand_span(1 << 22);
                hy = rand_span(1 << 22);
                push_query(hx, hy, hx + rand_span(shape_radius), hy + rand_span(shape_radius),
                           $urandom_range(0, shape_radius / 4),
                           $urandom_range(0, shape_radius / 4));
            end
        end
    endtask

    // Program vertex_count, load a fitting shape, then queue queries.
    task automatic shape_phase(input int unsigned count_cfg, input int unsigned k);
        int unsigned verts;
        verts        = (count_cfg > MAX_VERTS) ? MAX_VERTS : count_cfg;
        shape_radius = 1 << $urandom_range(8, 20);
        set_vertex_count(count_cfg);
        if (verts >= 2)
            load_shape(verts);
        feed_queries(verts, k);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_ready        = 1'b0;
        i_op           = bcip_pkg::OP_LOAD;
        i_vertex_index = '0;
        i_vertex_x     = '0;
        i_vertex_y     = '0;
        i_hull_x       = '0;
        i_hull_y       = '0;
        i_box_x        = '0;
        i_box_y        = '0;
        i_half_width   = '0;
        i_half_height  = '0;
        i_cfg_valid    = 1'b0;
        i_vertex_count = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // No vertices: a query misses even at the extremes; load the
        // extreme coordinates into the first and last slots.
        set_vertex_count(0);
        push_query(C_MAX, C_MIN, C_MIN, C_MAX, H_MAX, H_MAX);
        push_load(MAX_VERTS - 1, C_MIN, C_MAX);
        push_load(0, C_MAX, C_MIN);
        settle(SETTLE_CYCLES);

        // One vertex has no edge: still a miss.
        set_vertex_count(1);
        push_query(C_MIN, C_MAX, C_MAX, C_MIN, 0, 0);
        settle(SETTLE_CYCLES);

        // Closed 10 x 10 square: each corner as the first hit, a miss,
        // points on the edges, and an offset origin.
        set_vertex_count(5);
        push_load(0, 0, 0);
        push_load(1, 10 * UNIT, 0);
        push_load(2, 10 * UNIT, 10 * UNIT);
        push_load(3, 0, 10 * UNIT);
        push_load(4, 0, 0);
        push_query(0, 0, 5 * UNIT, 5 * UNIT, UNIT, UNIT);
        push_query(0, 0, 10 * UNIT, 10 * UNIT, 2 * UNIT, 2 * UNIT);
        push_query(0, 0, 0, 10 * UNIT, 2 * UNIT, 2 * UNIT);
        push_query(0, 0, 0, 0, 2 * UNIT, 2 * UNIT);
        push_query(0, 0, 30 * UNIT, 30 * UNIT, UNIT, UNIT);
        // on the bottom edge (inside), top edge (outside),
        // right edge (outside) and left edge (inside)
        push_query(0, 0, 5 * UNIT, 0, 0, 0);
        push_query(0, 0, 5 * UNIT, 10 * UNIT, 0, 0);
        push_query(0, 0, 10 * UNIT, 5 * UNIT, 0, 0);
        push_query(0, 0, 0, 5 * UNIT, 0, 0);
        push_query(-100 * UNIT, -100 * UNIT, -95 * UNIT, -95 * UNIT, UNIT, UNIT);
        push_query(C_MAX, C_MIN, C_MIN, C_MAX, H_MAX, 0);
        push_query(C_MIN, C_MAX, C_MAX, C_MIN, 0, H_MAX);
        settle(SETTLE_CYCLES);

        // Hold the verdict side off for a long stretch so the block fills
        // and stalls its input while words keep coming.
        bursty = 1'b1;
        shape_phase(3, 24);
        ready_hold = 400;
        settle(SETTLE_CYCLES);

        // Pause the sender mid-phase until every verdict is back.
        shape_phase(4, 12);
        settle(0);
        feed_queries(4, 12);
        settle(SETTLE_CYCLES);

        // Full store, then counts past the store size.
        shape_phase(MAX_VERTS, 12);
        settle(SETTLE_CYCLES);
        shape_phase((1 << CNT_W) - 1, 8);
        settle(SETTLE_CYCLES);
        shape_phase($urandom_range(MAX_VERTS + 1, (1 << CNT_W) - 2), 6);
        settle(SETTLE_CYCLES);
        shape_phase(2, 15);
        settle(SETTLE_CYCLES);

        // Random phases, mostly small polygons, idling on and off.
        while (words_made < 760) begin
            bursty = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 7) == 0)
                shape_phase($urandom_range(0, (1 << CNT_W) - 1), $urandom_range(10, 30));
            else
                shape_phase($urandom_range(2, 16), $urandom_range(10, 30));
            settle(SETTLE_CYCLES);
        end

        // Last stretch at full rate.
        bursty = 1'b0;
        shape_phase($urandom_range(3, 12), 90);
        settle(SETTLE_CYCLES);

        if (mismatches == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

    // Give up well past the slowest legal run.
    initial begin
        #5_000_000;
        $display("testbench: FAIL");
        $finish;
    end

endmodule

>>> sim.f
hdl/bcip_pkg.sv
hdl/bcip_ram.sv
hdl/bcip_dp.sv
hdl/bcip_ctrl.sv
hdl/box_corner_in_polygon_test.sv
dv/testbench.sv
